@@ rtl/json_string_unescape_utf8_defines.svh @@
// Assertion macros shared by the JSON string unescaper RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/jsu_pkg.sv @@
// Shared types, codes and helpers for the JSON string unescaper.
// Used by jsu_front, jsu_fifo, jsu_back and the top level; depends on nothing.
package jsu_pkg;

  localparam int unsigned JSU_DESC_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_DONE       = 3'd1,
    ST_EXP_QUOTE  = 3'd2,
    ST_UNTERM_STR = 3'd3,
    ST_UNTERM_ESC = 3'd4,
    ST_TRUNC_UNI  = 3'd5,
    ST_BAD_HEX    = 3'd6,
    ST_BAD_ESC    = 3'd7
  } jsu_status_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_STR,
    M_ESC,
    M_HEX,
    M_AFT_HI,
    M_AFT_HI_BS
  } jsu_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    jsu_status_t status;
    logic        last;
  } jsu_out_t;

  // One queued burst: zero to two replacement characters, then a tail that is
  // either a status beat or up to four bytes.
  typedef struct packed {
    logic [1:0]      n_fffd;
    logic            is_status;
    jsu_status_t     status;
    logic [2:0]      tail_len;
    logic [3:0][7:0] tail;
  } jsu_desc_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } jsu_utf8_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  localparam logic [5:0] SURR_HI_TAG = 6'b110110;
  localparam logic [5:0] SURR_LO_TAG = 6'b110111;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // U+FFFD in UTF-8, first byte at index 0.
  localparam logic [2:0][7:0] FFFD_UTF8 = {8'hBD, 8'hBF, 8'hEF};

  function automatic jsu_utf8_t jsu_enc_cp(input logic [20:0] cp);
    jsu_utf8_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/jsu_front.sv @@
// Front end of the unescaper: scan state machine that classifies each beat
// and turns it into at most one burst descriptor. Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  jsu_in_t   in_item,
  output jsu_desc_t desc,
  output logic      desc_push
);

  jsu_mode_t   mode_r, mode_nxt;
  logic [11:0] hexv_r, hexv_nxt;
  logic [1:0]  hexc_r, hexc_nxt;
  logic        hexbad_r, hexbad_nxt;
  logic [9:0]  hh_r, hh_nxt;
  logic        hpend_r, hpend_nxt;

  logic [7:0]  c;
  logic        eot;
  logic [3:0]  dig;
  logic        dig_bad;
  logic [15:0] cpx;
  logic        is_hi, is_lo;
  logic [20:0] pair_cp;
  jsu_utf8_t   utf_w;
  logic        do_str, do_esc;

  assign c   = in_item.in_byte;
  assign eot = in_item.text_end;

  always_comb begin
    dig     = 4'd0;
    dig_bad = 1'b0;
    case (c) inside
      [CH_0:CH_9]:   dig = 4'(c - CH_0);
      [CH_LA:CH_LF]: dig = 4'(c - CH_LA + 8'd10);
      [CH_UA:CH_UF]: dig = 4'(c - CH_UA + 8'd10);
      default:       dig_bad = 1'b1;
    endcase
  end

  assign cpx     = {hexv_r, dig};
  assign is_hi   = (cpx[15:10] == SURR_HI_TAG);
  assign is_lo   = (cpx[15:10] == SURR_LO_TAG);
  assign pair_cp = SUPP_BASE + {1'b0, hh_r, cpx[9:0]};
  assign utf_w   = jsu_enc_cp(hpend_r ? pair_cp : {5'd0, cpx});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      hexv_r   <= '0;
      hexc_r   <= '0;
      hexbad_r <= 1'b0;
      hh_r     <= '0;
      hpend_r  <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      hexv_r   <= hexv_nxt;
      hexc_r   <= hexc_nxt;
      hexbad_r <= hexbad_nxt;
      hh_r     <= hh_nxt;
      hpend_r  <= hpend_nxt;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    hexv_nxt    = hexv_r;
    hexc_nxt    = hexc_r;
    hexbad_nxt  = hexbad_r;
    hh_nxt      = hh_r;
    hpend_nxt   = hpend_r;
    desc        = '0;
    desc.status = ST_NONE;
    do_str      = 1'b0;
    do_esc      = 1'b0;

    if (accept) begin
      case (mode_r)
        M_STR: do_str = 1'b1;
        M_ESC: do_esc = 1'b1;
        M_HEX: begin
          if (eot) begin
            desc.is_status = 1'b1;
            desc.status    = ST_TRUNC_UNI;
            mode_nxt       = M_IDLE;
            hpend_nxt      = 1'b0;
          end else if (hexc_r != 2'd3) begin
            hexv_nxt   = cpx[11:0];
            hexc_nxt   = hexc_r + 2'd1;
            hexbad_nxt = hexbad_r | dig_bad;
          end else if (hexbad_r || dig_bad) begin
            desc.is_status = 1'b1;
            desc.status    = ST_BAD_HEX;
            mode_nxt       = M_IDLE;
            hpend_nxt      = 1'b0;
          end else begin
            mode_nxt = M_STR;
            hexv_nxt = '0;
            hexc_nxt = '0;
            if (hpend_r) begin
              hpend_nxt = 1'b0;
              hh_nxt    = '0;
              if (is_lo) begin
                desc.tail_len = utf_w.len;
                desc.tail     = utf_w.b;
              end else begin
                desc.n_fffd = 2'd2;
              end
            end else if (is_hi) begin
              hh_nxt    = cpx[9:0];
              hpend_nxt = 1'b1;
              mode_nxt  = M_AFT_HI;
            end else if (is_lo) begin
              desc.n_fffd = 2'd1;
            end else begin
              desc.tail_len = utf_w.len;
              desc.tail     = utf_w.b;
            end
          end
        end
        M_AFT_HI: begin
          if (eot) begin
            desc.n_fffd    = 2'd1;
            desc.is_status = 1'b1;
            desc.status    = ST_UNTERM_STR;
            mode_nxt       = M_IDLE;
            hpend_nxt      = 1'b0;
          end else if (c == CH_BSLASH) begin
            mode_nxt = M_AFT_HI_BS;
          end else begin
            desc.n_fffd = 2'd1;
            hpend_nxt   = 1'b0;
            hh_nxt      = '0;
            do_str      = 1'b1;
          end
        end
        M_AFT_HI_BS: begin
          if (eot) begin
            desc.n_fffd    = 2'd1;
            desc.is_status = 1'b1;
            desc.status    = ST_UNTERM_ESC;
            mode_nxt       = M_IDLE;
            hpend_nxt      = 1'b0;
          end else if (c == CH_U) begin
            // The pending high half survives into the next escape.
            mode_nxt   = M_HEX;
            hexv_nxt   = '0;
            hexc_nxt   = '0;
            hexbad_nxt = 1'b0;
          end else begin
            desc.n_fffd = 2'd1;
            hpend_nxt   = 1'b0;
            hh_nxt      = '0;
            do_esc      = 1'b1;
          end
        end
        default: begin
          if (!eot && c == CH_QUOTE) begin
            mode_nxt  = M_STR;
            hpend_nxt = 1'b0;
            hh_nxt    = '0;
          end else begin
            desc.is_status = 1'b1;
            desc.status    = ST_EXP_QUOTE;
            mode_nxt       = M_IDLE;
            hpend_nxt      = 1'b0;
          end
        end
      endcase

      if (do_str) begin
        if (eot) begin
          desc.is_status = 1'b1;
          desc.status    = ST_UNTERM_STR;
          mode_nxt       = M_IDLE;
          hpend_nxt      = 1'b0;
        end else if (c == CH_QUOTE) begin
          desc.is_status = 1'b1;
          desc.status    = ST_DONE;
          mode_nxt       = M_IDLE;
          hpend_nxt      = 1'b0;
        end else if (c == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          desc.tail_len = 3'd1;
          desc.tail[0]  = c;
          mode_nxt      = M_STR;
        end
      end

      if (do_esc) begin
        if (eot) begin
          desc.is_status = 1'b1;
          desc.status    = ST_UNTERM_ESC;
          mode_nxt       = M_IDLE;
          hpend_nxt      = 1'b0;
        end else begin
          desc.tail_len = 3'd1;
          mode_nxt      = M_STR;
          case (c)
            CH_QUOTE:  desc.tail[0] = CH_QUOTE;
            CH_BSLASH: desc.tail[0] = CH_BSLASH;
            CH_SLASH:  desc.tail[0] = CH_SLASH;
            CH_B:      desc.tail[0] = CTL_BS;
            CH_F:      desc.tail[0] = CTL_FF;
            CH_N:      desc.tail[0] = CTL_LF;
            CH_R:      desc.tail[0] = CTL_CR;
            CH_T:      desc.tail[0] = CTL_TAB;
            CH_U: begin
              desc.tail_len = 3'd0;
              mode_nxt      = M_HEX;
              hexv_nxt      = '0;
              hexc_nxt      = '0;
              hexbad_nxt    = 1'b0;
            end
            default: begin
              desc.tail_len  = 3'd0;
              desc.is_status = 1'b1;
              desc.status    = ST_BAD_ESC;
              mode_nxt       = M_IDLE;
              hpend_nxt      = 1'b0;
            end
          endcase
        end
      end
    end
  end

  assign desc_push = accept &&
                     (desc.n_fffd != 2'd0 || desc.is_status || desc.tail_len != 3'd0);

endmodule

@@ rtl/jsu_fifo.sv @@
// Short descriptor queue between the front end and the back end.
// Depends on jsu_pkg for the descriptor type.
`include "json_string_unescape_utf8_defines.svh"

module jsu_fifo import jsu_pkg::*; #(
  parameter int unsigned DEPTH = JSU_DESC_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  jsu_desc_t wr_desc,
  output logic      full,
  input  logic      pop,
  output jsu_desc_t head,
  output logic      empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsu_desc_t       mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_desc;
    end
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `JSU_ASSERT_NOW(a_no_push_full, push, !full, "descriptor written into a full queue")
  `JSU_ASSERT_NOW(a_no_pop_empty, pop, !empty, "descriptor popped from an empty queue")

endmodule

@@ rtl/jsu_back.sv @@
// Back end of the unescaper: walks the head descriptor one result beat per
// cycle, while the output is drained, into the output register. Depends on jsu_pkg.
`include "json_string_unescape_utf8_defines.svh"

module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  jsu_desc_t head,
  input  logic      q_empty,
  output logic      q_pop,
  output jsu_out_t  out_data,
  output logic      out_empty,
  input  logic      out_pop
);

  logic [2:0] step_r, step_nxt;
  jsu_out_t   obuf_r, obuf_nxt;
  logic       ovalid_r, ovalid_nxt;

  logic [2:0] three_nf;
  logic [2:0] tail_cnt;
  logic [3:0] total;
  logic       in_fffd;
  logic [1:0] fidx;
  logic [1:0] tidx;
  logic       is_last;
  logic       load;
  jsu_out_t   beat;

  assign three_nf = {head.n_fffd, 1'b0} + {1'b0, head.n_fffd};
  assign tail_cnt = head.is_status ? 3'd1 : head.tail_len;
  assign total    = {1'b0, three_nf} + {1'b0, tail_cnt};
  assign in_fffd  = (step_r < three_nf);
  assign fidx     = (step_r >= 3'd3) ? 2'(step_r - 3'd3) : step_r[1:0];
  assign tidx     = 2'(step_r - three_nf);
  assign is_last  = (({1'b0, step_r} + 4'd1) == total);

  // The output register takes a queued beat whenever it is free or being drained.
  assign load  = !q_empty && (!ovalid_r || out_pop);
  assign q_pop = load && is_last;

  always_comb begin
    beat      = '0;
    beat.last = is_last;
    if (in_fffd) begin
      beat.out_byte   = FFFD_UTF8[fidx];
      beat.byte_valid = 1'b1;
      beat.status     = ST_NONE;
    end else if (head.is_status) begin
      beat.status = head.status;
    end else begin
      beat.out_byte   = head.tail[tidx];
      beat.byte_valid = 1'b1;
      beat.status     = ST_NONE;
    end
  end

  always_comb begin
    step_nxt   = step_r;
    obuf_nxt   = obuf_r;
    ovalid_nxt = ovalid_r;
    if (load) begin
      obuf_nxt   = beat;
      ovalid_nxt = 1'b1;
      step_nxt   = is_last ? 3'd0 : step_r + 3'd1;
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obuf_r <= obuf_nxt;
  end

  assign out_data  = obuf_r;
  assign out_empty = !ovalid_r;

  `JSU_ASSERT_NOW(a_burst_has_head, step_r != 3'd0, !q_empty, "burst lost its descriptor")
  `JSU_ASSERT_NOW(a_step_in_range, !q_empty, ({1'b0, step_r} < total), "burst step past its end")

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
// Top level of the JSON string unescaper: scan front end, descriptor queue
// and result back end. Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
// Usage: feed the string literal, opening quote first, one byte per beat on
// in_data (push/full). A beat with text_end set carries no byte and ends the
// text. Decoded UTF-8 bytes and status beats (done or an error code) leave on
// out_data (empty/pop), in order; last marks the final result of an input beat.
// Each input beat is scanned in the cycle it is accepted and yields zero to six
// result beats. A result passes through the descriptor queue and the output
// register to out_data. The back end puts out one result beat per cycle
// while the receiver pops, so the block takes one input beat per cycle while
// beats yield at most one result; a beat that yields k results holds the back
// end until all k are out, and the descriptor queue (DESC_DEPTH entries) soaks
// up such bursts before full is raised. When the receiver stops popping, the
// output register holds its beat, the queue fills, and full stalls the sender.
// Reset returns the scanner to waiting for an opening quote and empties the
// queue and the output register; no clearing pass is needed.
module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int unsigned DESC_DEPTH = JSU_DESC_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  jsu_in_t  in_data,
  output logic     out_empty,
  input  logic     out_pop,
  output jsu_out_t out_data
);

  logic      accept;
  jsu_desc_t desc;
  logic      desc_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  jsu_desc_t q_head;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .desc      (desc),
    .desc_push (desc_push)
  );

  jsu_fifo #(
    .DEPTH (DESC_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (desc_push),
    .wr_desc (desc),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
